// ===== rtl/urtl_pkg.sv =====
// ultrasonic ranging controller: shared types and constants
// phase codes, register indexes, reset values and counter widths
// no dependencies
`timescale 1ns / 1ps

package urtl_pkg;

    // millisecond counter width
    localparam int MS_COUNT_BITS = 16;
    // width used for comparing the counter with 8 and 16 bit registers
    localparam int CMP_W  = (MS_COUNT_BITS > 16) ? MS_COUNT_BITS : 16;
    // product of the counter and cm_per_ms
    localparam int PROD_W = MS_COUNT_BITS + 8;

    localparam logic [MS_COUNT_BITS-1:0] CNT_MAX = {MS_COUNT_BITS{1'b1}};
    localparam logic [15:0] DIST_MAX = 16'hFFFF;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [2:0] {
        PH_TRIG      = 3'd0,
        PH_RISE      = 3'd1,
        PH_HIGH      = 3'd2,
        PH_BLINK_ON  = 3'd3,
        PH_BLINK_OFF = 3'd4,
        PH_PAUSE     = 3'd5
    } phase_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_THRESHOLD_CM    = 3'd0,
        CFG_TRIGGER_SAMPLES = 3'd1,
        CFG_RISE_TIMEOUT_MS = 3'd2,
        CFG_HIGH_TIMEOUT_MS = 3'd3,
        CFG_CM_PER_MS       = 3'd4,
        CFG_PAUSE_MS        = 3'd5
    } cfg_index_t;

    localparam logic [15:0] RST_THRESHOLD_CM    = 16'd20;
    localparam logic [7:0]  RST_TRIGGER_SAMPLES = 8'd10;
    localparam logic [7:0]  RST_RISE_TIMEOUT_MS = 8'd10;
    localparam logic [7:0]  RST_HIGH_TIMEOUT_MS = 8'd30;
    localparam logic [7:0]  RST_CM_PER_MS       = 8'd17;
    localparam logic [15:0] RST_PAUSE_MS        = 16'd100;

endpackage

// ===== rtl/ultrasonic_range_threshold_led.sv =====
// ultrasonic ranging controller with a distance threshold LED
// each result word is registered at the edge that accepts its sample word
// throughput: one sample word per cycle if m_tready allows; result drains as next word enters
// all phase and counter state updates at the accepting edge, so the state path sets the rate
// reset: asynchronous, active low; config registers return to defaults, phase to trigger
// depends on urtl_pkg
`timescale 1ns / 1ps

module ultrasonic_range_threshold_led
(
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [urtl_pkg::CFG_ADDR_W-1:0]   cfg_index,
    input  logic [urtl_pkg::CFG_DATA_W-1:0]   cfg_data,
    // sample words
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [urtl_pkg::IN_DATA_W-1:0]    s_tdata,   // echo_level, ms_tick, zero pad
    // result words
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [urtl_pkg::OUT_DATA_W-1:0]   m_tdata    // trigger_out, led_out,
                                                         // distance_cm[15:0], distance_valid,
                                                         // sensor_error, zero pad
);

    localparam int MB = urtl_pkg::MS_COUNT_BITS;
    localparam int CW = urtl_pkg::CMP_W;
    localparam int PW = urtl_pkg::PROD_W;

    // configuration registers
    logic [15:0] threshold_cm_reg;
    logic [7:0]  trigger_samples_reg;
    logic [7:0]  rise_timeout_ms_reg;
    logic [7:0]  high_timeout_ms_reg;
    logic [7:0]  cm_per_ms_reg;
    logic [15:0] pause_ms_reg;

    // controller state
    urtl_pkg::phase_t phase_reg, phase_next;
    logic [MB-1:0]    ms_count_reg, ms_count_next;
    logic [7:0]       trigger_count_reg, trigger_count_next;
    logic             led_on_reg, led_on_next;
    logic [15:0]      last_distance_reg, last_distance_next;

    // result register
    logic                             m_tvalid_reg;
    logic [urtl_pkg::OUT_DATA_W-1:0]  m_tdata_reg;

    logic          echo;
    logic          tick;
    logic          accept;
    logic          trig;
    logic          valid;
    logic          err;
    logic [MB-1:0] cnt_ticked;
    logic [7:0]    trig_len;
    logic [7:0]    trig_base;
    logic [7:0]    trig_cnt_inc;
    logic [PW-1:0] product;
    logic [15:0]   dist_sat;
    logic          delay_done;
    logic          rise_to;
    logic          high_to;

    assign echo   = s_tdata[0];
    assign tick   = s_tdata[1];
    assign accept = s_tvalid && s_tready;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // counter after this step's tick, saturating
    assign cnt_ticked = (tick && (ms_count_reg != urtl_pkg::CNT_MAX))
                        ? ms_count_reg + MB'(1) : ms_count_reg;

    assign delay_done = (CW'(cnt_ticked) >= CW'(pause_ms_reg))
                        || (cnt_ticked == urtl_pkg::CNT_MAX);
    assign rise_to    = (CW'(cnt_ticked) > CW'(rise_timeout_ms_reg))
                        || (cnt_ticked == urtl_pkg::CNT_MAX);
    assign high_to    = (CW'(cnt_ticked) > CW'(high_timeout_ms_reg))
                        || (cnt_ticked == urtl_pkg::CNT_MAX);

    assign product  = PW'(ms_count_reg) * PW'(cm_per_ms_reg);
    assign dist_sat = (product > PW'(urtl_pkg::DIST_MAX)) ? urtl_pkg::DIST_MAX
                                                         : product[15:0];

    assign trig_len     = (trigger_samples_reg == 8'd0) ? 8'd1 : trigger_samples_reg;
    // unused phase codes restart the trigger count
    assign trig_base    = (phase_reg == urtl_pkg::PH_TRIG) ? trigger_count_reg : 8'd0;
    assign trig_cnt_inc = trig_base + 8'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        ms_count_next      = ms_count_reg;
        trigger_count_next = trigger_count_reg;
        led_on_next        = led_on_reg;
        last_distance_next = last_distance_reg;
        trig               = 1'b0;
        valid              = 1'b0;
        err                = 1'b0;

        unique case (phase_reg)
            urtl_pkg::PH_RISE:
            begin
                if (echo)
                begin
                    phase_next    = urtl_pkg::PH_HIGH;
                    ms_count_next = '0;
                end
                else
                begin
                    ms_count_next = cnt_ticked;
                    err           = rise_to;
                end
            end
            urtl_pkg::PH_HIGH:
            begin
                if (!echo)
                begin
                    last_distance_next = dist_sat;
                    led_on_next        = dist_sat < threshold_cm_reg;
                    valid              = 1'b1;
                    phase_next         = urtl_pkg::PH_PAUSE;
                    ms_count_next      = '0;
                end
                else
                begin
                    ms_count_next = cnt_ticked;
                    err           = high_to;
                end
            end
            urtl_pkg::PH_BLINK_ON:
            begin
                ms_count_next = cnt_ticked;
                if (delay_done)
                begin
                    led_on_next   = 1'b0;
                    phase_next    = urtl_pkg::PH_BLINK_OFF;
                    ms_count_next = '0;
                end
            end
            urtl_pkg::PH_BLINK_OFF,
            urtl_pkg::PH_PAUSE:
            begin
                ms_count_next = cnt_ticked;
                if (delay_done)
                begin
                    phase_next = (phase_reg == urtl_pkg::PH_PAUSE) ? urtl_pkg::PH_TRIG
                                                                   : urtl_pkg::PH_PAUSE;
                    ms_count_next      = '0;
                    trigger_count_next = 8'd0;
                end
            end
            default:
            begin
                trig               = 1'b1;
                phase_next         = urtl_pkg::PH_TRIG;
                trigger_count_next = trig_cnt_inc;
                if ((trig_cnt_inc >= trig_len) || (trig_cnt_inc == 8'd0))
                begin
                    phase_next         = urtl_pkg::PH_RISE;
                    ms_count_next      = '0;
                    trigger_count_next = 8'd0;
                end
            end
        endcase

        if (err)
        begin
            led_on_next   = 1'b1;
            phase_next    = urtl_pkg::PH_BLINK_ON;
            ms_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_cm_reg    <= urtl_pkg::RST_THRESHOLD_CM;
            trigger_samples_reg <= urtl_pkg::RST_TRIGGER_SAMPLES;
            rise_timeout_ms_reg <= urtl_pkg::RST_RISE_TIMEOUT_MS;
            high_timeout_ms_reg <= urtl_pkg::RST_HIGH_TIMEOUT_MS;
            cm_per_ms_reg       <= urtl_pkg::RST_CM_PER_MS;
            pause_ms_reg        <= urtl_pkg::RST_PAUSE_MS;
        end
        else if (cfg_wr_en)
        begin
            // indexes past the register list are dropped
            priority case (cfg_index)
                urtl_pkg::CFG_THRESHOLD_CM:    threshold_cm_reg    <= cfg_data;
                urtl_pkg::CFG_TRIGGER_SAMPLES: trigger_samples_reg <= cfg_data[7:0];
                urtl_pkg::CFG_RISE_TIMEOUT_MS: rise_timeout_ms_reg <= cfg_data[7:0];
                urtl_pkg::CFG_HIGH_TIMEOUT_MS: high_timeout_ms_reg <= cfg_data[7:0];
                urtl_pkg::CFG_CM_PER_MS:       cm_per_ms_reg       <= cfg_data[7:0];
                urtl_pkg::CFG_PAUSE_MS:        pause_ms_reg        <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= urtl_pkg::PH_TRIG;
            ms_count_reg      <= '0;
            trigger_count_reg <= 8'd0;
            led_on_reg        <= 1'b0;
            last_distance_reg <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg         <= phase_next;
            ms_count_reg      <= ms_count_next;
            trigger_count_reg <= trigger_count_next;
            led_on_reg        <= led_on_next;
            last_distance_reg <= last_distance_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {4'd0, err, valid, last_distance_next, led_on_next, trig};
        end
    end

endmodule

// ===== bench/tb.sv =====
// self-checking bench for the ultrasonic ranging controller with threshold LED
// drives sample words with random bursts and gaps, predicts every result word
// depends on urtl_pkg and ultrasonic_range_threshold_led
`timescale 1ns / 1ps

module tb;

    import urtl_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int LONG_HOLD   = 300;
    localparam int MAX_REPORTS = 10;

    // indexes past the last register, which the block must ignore
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam cfg_index_t REG_ORDER [6] = '{CFG_THRESHOLD_CM, CFG_TRIGGER_SAMPLES,
                                            CFG_RISE_TIMEOUT_MS, CFG_HIGH_TIMEOUT_MS,
                                            CFG_CM_PER_MS, CFG_PAUSE_MS};

    // result word fields, trigger_out in bit 0
    typedef struct packed {
        logic        err;
        logic        valid;
        logic [15:0] dist_cm;
        logic        led;
        logic        trig;
    } result_t;

    typedef struct packed {
        logic        echo;
        logic        tick;
        logic        typed;
        logic        trig;
        logic        led;
        logic [15:0] dist_cm;
        logic        valid;
        logic        err;
    } dir_row_t;

    // run with: threshold max, trigger length 0, rise timeout 0, high timeout 2,
    // 255 cm per ms, no pause
    localparam int DIR_N = 22;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        '{0, 0, 1, 1, 0, 0,   0, 0},   // trigger of zero length acts as one step
        '{0, 1, 1, 0, 1, 0,   0, 1},   // first tick past a zero rise timeout
        '{0, 0, 0, 0, 0, 0,   0, 0},   // blink on ends with no tick
        '{1, 1, 0, 0, 0, 0,   0, 0},
        '{1, 0, 0, 0, 0, 0,   0, 0},   // pause of zero still takes a step
        '{1, 1, 0, 0, 0, 0,   0, 0},   // trigger while echo already high
        '{1, 1, 0, 0, 0, 0,   0, 0},
        '{1, 1, 0, 0, 0, 0,   0, 0},
        '{1, 1, 0, 0, 0, 0,   0, 0},
        '{0, 1, 1, 0, 1, 510, 1, 0},   // 2 ms at 255 cm per ms
        '{0, 0, 0, 0, 0, 0,   0, 0},
        '{0, 0, 0, 0, 0, 0,   0, 0},
        '{1, 0, 0, 0, 0, 0,   0, 0},
        '{1, 1, 0, 0, 0, 0,   0, 0},
        '{1, 1, 0, 0, 0, 0,   0, 0},
        '{1, 1, 1, 0, 1, 510, 0, 1},   // echo held too long, distance kept
        '{0, 0, 0, 0, 0, 0,   0, 0},
        '{0, 0, 0, 0, 0, 0,   0, 0},
        '{0, 0, 0, 0, 0, 0,   0, 0},
        '{0, 0, 0, 0, 0, 0,   0, 0},
        '{1, 0, 0, 0, 0, 0,   0, 0},
        '{0, 0, 0, 0, 0, 0,   0, 0}    // zero width pulse
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic hold_req = 1'b0;

    // predicted block state and register copies
    phase_t                   ph;
    logic [MS_COUNT_BITS-1:0] ms_cnt;
    logic [7:0]               trig_cnt;
    logic                     led;
    logic [15:0]              last_dist;
    logic [15:0]              thr_cm;
    logic [7:0]               trig_len;
    logic [7:0]               rise_to;
    logic [7:0]               high_to;
    logic [7:0]               cm_ms;
    logic [15:0]              pause_len;

    result_t     due_results [$];
    logic [15:0] cfg_vals [6];
    int          burst_left = 0;
    int          fail_count = 0;
    int          idle_cycles = 0;

    ultrasonic_range_threshold_led dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void bump_ms(logic tick);
        if (tick && ms_cnt != CNT_MAX)
            ms_cnt = ms_cnt + 1'b1;
    endfunction

    function automatic logic ms_expired(logic [7:0] limit);
        return (ms_cnt > limit) || (ms_cnt == CNT_MAX);
    endfunction

    function automatic logic delay_over();
        return (ms_cnt >= pause_len) || (ms_cnt == CNT_MAX);
    endfunction

    function automatic void latch_reg(logic [CFG_ADDR_W-1:0] idx, logic [15:0] v);
        case (idx)
            CFG_THRESHOLD_CM:    thr_cm = v;
            CFG_TRIGGER_SAMPLES: trig_len = v[7:0];
            CFG_RISE_TIMEOUT_MS: rise_to = v[7:0];
            CFG_HIGH_TIMEOUT_MS: high_to = v[7:0];
            CFG_CM_PER_MS:       cm_ms = v[7:0];
            CFG_PAUSE_MS:        pause_len = v;
            default: ;
        endcase
    endfunction

    function automatic result_t next_range_result(logic echo, logic tick);
        result_t           r;
        logic [PROD_W-1:0] prod;
        logic [7:0]        len;
        r = '0;
        case (ph)
            PH_RISE:
            begin
                if (echo)
                begin
                    ph = PH_HIGH;
                    ms_cnt = '0;
                end
                else
                begin
                    bump_ms(tick);
                    r.err = ms_expired(rise_to);
                end
            end
            PH_HIGH:
            begin
                if (!echo)
                begin
                    prod = PROD_W'(ms_cnt) * PROD_W'(cm_ms);
                    last_dist = (prod > DIST_MAX) ? DIST_MAX : prod[15:0];
                    led = (last_dist < thr_cm);
                    r.valid = 1'b1;
                    ph = PH_PAUSE;
                    ms_cnt = '0;
                end
                else
                begin
                    bump_ms(tick);
                    r.err = ms_expired(high_to);
                end
            end
            PH_BLINK_ON:
            begin
                bump_ms(tick);
                if (delay_over())
                begin
                    led = 1'b0;
                    ph = PH_BLINK_OFF;
                    ms_cnt = '0;
                end
            end
            PH_BLINK_OFF, PH_PAUSE:
            begin
                bump_ms(tick);
                if (delay_over())
                begin
                    ph = (ph == PH_PAUSE) ? PH_TRIG : PH_PAUSE;
                    ms_cnt = '0;
                    trig_cnt = '0;
                end
            end
            default:
            begin
                len = (trig_len == 8'd0) ? 8'd1 : trig_len;
                if (ph != PH_TRIG)
                begin
                    ph = PH_TRIG;
                    trig_cnt = '0;
                end
                r.trig = 1'b1;
                trig_cnt = trig_cnt + 1'b1;
                if (trig_cnt >= len || trig_cnt == 8'd0)
                begin
                    ph = PH_RISE;
                    ms_cnt = '0;
                    trig_cnt = '0;
                end
            end
        endcase
        if (r.err)
        begin
            led = 1'b1;
            ph = PH_BLINK_ON;
            ms_cnt = '0;
        end
        r.led = led;
        r.dist_cm = last_dist;
        return r;
    endfunction

    task automatic program_regs(input bit with_spare);
        int                    i;
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_DATA_W-1:0] val;
        for (i = 0; i < (with_spare ? 8 : 6); i++)
        begin
            if (i < 6)
            begin
                idx = REG_ORDER[i];
                val = cfg_vals[i];
            end
            else
            begin
                idx = (i == 6) ? CFG_SPARE_LO : CFG_SPARE_HI;
                val = 16'($urandom);
            end
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            latch_reg(idx, val);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // offer one sample word, predict its result once it is taken
    task automatic send_sample(input logic echo, input logic tick, input bit typed,
                               input result_t typed_res);
        result_t r;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata <= {{(IN_DATA_W-2){1'b0}}, tick, echo};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = next_range_result(echo, tick);
        due_results.push_back(typed ? typed_res : r);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                       : $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // quiet input until every result word is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int       i;
        int       p;
        int       n;
        int       n_items;
        int       tick_div;
        logic     echo;
        logic     tick;
        result_t  typed_res;
        dir_row_t row;

        thr_cm = RST_THRESHOLD_CM;
        trig_len = RST_TRIGGER_SAMPLES;
        rise_to = RST_RISE_TIMEOUT_MS;
        high_to = RST_HIGH_TIMEOUT_MS;
        cm_ms = RST_CM_PER_MS;
        pause_len = RST_PAUSE_MS;
        ph = PH_TRIG;
        ms_cnt = '0;
        trig_cnt = '0;
        led = 1'b0;
        last_dist = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cfg_vals = '{16'hFFFF, 16'd0, 16'd0, 16'd2, 16'd255, 16'd0};
        program_regs(1'b0);
        for (i = 0; i < DIR_N; i++)
        begin
            row = DIR_ROWS[i];
            typed_res.trig = row.trig;
            typed_res.led = row.led;
            typed_res.dist_cm = row.dist_cm;
            typed_res.valid = row.valid;
            typed_res.err = row.err;
            send_sample(row.echo, row.tick, row.typed, typed_res);
        end
        drain_results();

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    cfg_vals = '{16'd20, 16'd10, 16'd10, 16'd30, 16'd17, 16'd5};
                    tick_div = 2;
                    n_items = 80;
                end
                1:
                begin
                    cfg_vals = '{16'd0, 16'd255, 16'd3, 16'd6, 16'd1, 16'd2};
                    tick_div = 1;
                    n_items = 180;
                end
                2:
                begin
                    cfg_vals = '{16'hFFFF, 16'd1, 16'd255, 16'd255, 16'd255, 16'd0};
                    tick_div = 3;
                    n_items = 90;
                end
                3:
                begin
                    // junk in the upper byte of the narrow registers
                    cfg_vals[0] = 16'($urandom_range(0, 300));
                    cfg_vals[1] = {8'($urandom), 8'($urandom_range(1, 8))};
                    cfg_vals[2] = {8'($urandom), 8'($urandom_range(0, 4))};
                    cfg_vals[3] = {8'($urandom), 8'($urandom_range(0, 8))};
                    cfg_vals[4] = 16'($urandom);
                    cfg_vals[5] = 16'($urandom_range(0, 4));
                    tick_div = 2;
                    n_items = 100;
                end
                default:
                begin
                    cfg_vals = '{16'd30, 16'd2, 16'd0, 16'd0, 16'd9, 16'd1};
                    tick_div = 0;
                    n_items = 80;
                end
            endcase
            program_regs(p == 2);
            for (n = 0; n < n_items; n++)
            begin
                if (p == 2 && n == 30)
                    hold_req <= 1'b1;
                tick = ($urandom_range(0, tick_div) == 0);
                // echo follows a plausible pulse, with some noise on top
                case (ph)
                    PH_RISE: echo = ($urandom_range(0, 5) == 0);
                    PH_HIGH: echo = ($urandom_range(0, 7) != 0);
                    default: echo = 1'b0;
                endcase
                if ($urandom_range(0, 9) == 0)
                    echo = 1'($urandom_range(0, 1));
                send_sample(echo, tick, 1'b0, '0);
            end
            drain_results();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0 && due_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : sink_pattern
        int mode;
        int span;
        int beat;
        bit held;
        held = 1'b0;
        beat = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                // long stall so the block backs up into its input
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(20, 80);
                repeat (span)
                begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= (beat % 4 != 3);
                        2: m_tready <= 1'($urandom_range(0, 1));
                        default: m_tready <= ($urandom_range(0, 7) != 0);
                    endcase
                    beat++;
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[19:0]);
            if (due_results.size() == 0)
            begin
                if (fail_count < MAX_REPORTS)
                    $display("unexpected word: trig=%0d led=%0d dist=%0d valid=%0d err=%0d",
                             got.trig, got.led, got.dist_cm, got.valid, got.err);
                fail_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (got.trig !== want.trig || got.led !== want.led
                    || got.dist_cm !== want.dist_cm
                    || got.valid !== want.valid || got.err !== want.err)
                begin
                    if (fail_count < MAX_REPORTS)
                    begin
                        $display("mismatch at %0t: want trig=%0d led=%0d dist=%0d valid=%0d err=%0d",
                                 $realtime, want.trig, want.led, want.dist_cm, want.valid,
                                 want.err);
                        $display("    got trig=%0d led=%0d dist=%0d valid=%0d err=%0d",
                                 got.trig, got.led, got.dist_cm, got.valid, got.err);
                    end
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/urtl_pkg.sv
rtl/ultrasonic_range_threshold_led.sv
bench/tb.sv
